// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gprp assertion failed");
// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gprp assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/gprp_pkg.sv =====
// shared types and constants of the grid point rotate and project block
`timescale 1ns / 1ps
package gprp_pkg;

   // rotation center
   localparam int CENTER_X = 400;
   localparam int CENTER_Y = 600;

   // default limit on samples per row
   localparam int MAX_COLUMNS_DEF = 1024;

   // width of the columns register
   localparam int COLS_W = 11;

   // grid position width
   localparam int POS_W = 21;

   // depth of the queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;

   // register indexes of the configuration port
   typedef enum logic [3:0] {
      CSR_COS_A        = 4'd0,
      CSR_SIN_A        = 4'd1,
      CSR_COS_B        = 4'd2,
      CSR_SIN_B        = 4'd3,
      CSR_STEP_COL     = 4'd4,
      CSR_STEP_ROW     = 4'd5,
      CSR_HEIGHT_SCALE = 4'd6,
      CSR_COLUMNS      = 4'd7
   } csr_index_type;

   // configuration registers
   typedef struct packed {
      logic signed [15:0] cos_a;
      logic signed [15:0] sin_a;
      logic signed [15:0] cos_b;
      logic signed [15:0] sin_b;
      logic [9:0]         step_col;
      logic [9:0]         step_row;
      logic signed [10:0] height_scale;
      logic [COLS_W-1:0]  columns;
   } csr_type;

   // one classified sample handed from front to back
   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic signed [15:0] height;
      logic signed [15:0] low;
      logic signed [15:0] high;
   } entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== hw/rtl/gprp_front.sv =====
// front part: grid position stepping and running height range
`timescale 1ns / 1ps
module gprp_front #(
   parameter int MAX_COLUMNS = gprp_pkg::MAX_COLUMNS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_height,
   input  logic                   req_frame_start,
   input  gprp_pkg::csr_type      csr,
   input  gprp_pkg::q_status_type q_status,
   output logic                   push,
   output gprp_pkg::entry_type    push_data
);
   import gprp_pkg::*;

   localparam int CI_W  = $clog2(MAX_COLUMNS);
   localparam int NC_W  = $clog2(MAX_COLUMNS + 1);
   localparam int CMP_W = (NC_W > COLS_W) ? NC_W : COLS_W;
   localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_COLUMNS);

   logic [CI_W-1:0]    ci_ff, ci_in;
   logic [POS_W-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic signed [15:0] lo_ff, lo_in, hi_ff, hi_in;

   logic [CMP_W-1:0]   cols_w, ncols, ci_base, ci_next;
   logic [POS_W-1:0]   gx_base, gy_base, gy_cur, x_cur;
   logic [POS_W:0]     sum_x, sum_y;
   logic signed [15:0] lo_base, hi_base;

   // accept while the queue has room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // column count clamp and position step
   always_comb begin
      cols_w = CMP_W'(csr.columns);
      if (cols_w == '0) begin
         ncols = CMP_W'(1);
      end else if (cols_w > MAX_W) begin
         ncols = MAX_W;
      end else begin
         ncols = cols_w;
      end

      ci_base = req_frame_start ? '0 : CMP_W'(ci_ff);
      gx_base = req_frame_start ? '0 : gx_ff;
      gy_base = req_frame_start ? '0 : gy_ff;
      lo_base = req_frame_start ? 16'sh7FFF : lo_ff;
      hi_base = req_frame_start ? 16'sh8000 : hi_ff;

      // row ended under a smaller column count
      if (ci_base >= ncols) begin
         ci_base = '0;
         gx_base = '0;
      end

      sum_y  = {1'b0, gy_base} + (POS_W + 1)'(csr.step_row);
      sum_x  = {1'b0, gx_base} + (POS_W + 1)'(csr.step_col);
      gy_cur = (ci_base == '0) ? (sum_y[POS_W] ? '1 : sum_y[POS_W-1:0]) : gy_base;
      x_cur  = sum_x[POS_W] ? '1 : sum_x[POS_W-1:0];

      lo_in = (req_height < lo_base) ? req_height : lo_base;
      hi_in = (req_height > hi_base) ? req_height : hi_base;
      gy_in = gy_cur;

      // advance the column, wrap at row end
      ci_next = ci_base + CMP_W'(1);
      if (ci_next >= ncols) begin
         ci_in = '0;
         gx_in = '0;
      end else begin
         ci_in = ci_next[CI_W-1:0];
         gx_in = x_cur;
      end

      push_data.x      = x_cur;
      push_data.y      = gy_cur;
      push_data.height = req_height;
      push_data.low    = lo_in;
      push_data.high   = hi_in;
   end

   // grid state
   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff <= '0;
         gx_ff <= '0;
         gy_ff <= '0;
         lo_ff <= 16'sh7FFF;
         hi_ff <= 16'sh8000;
      end else if (push) begin
         ci_ff <= ci_in;
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule

// ===== hw/rtl/gprp_queue.sv =====
// short queue between the front and back parts
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gprp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gprp_pkg::entry_type    push_data,
   input  logic                   pop,
   output gprp_pkg::entry_type    pop_data,
   output gprp_pkg::q_status_type q_status
);
   import gprp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data       = slot_ff[rd_ptr_ff];

   // fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // pointers and level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_CLK(a_no_pop_empty, clock, reset, pop |-> count_ff != '0)
   `ASSERT_CLK(a_no_push_full, clock, reset, push |-> count_ff != CNT_W'(QUEUE_DEPTH))
   `ASSERT_CLK(a_push_grows, clock, reset, (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== hw/rtl/gprp_back.sv =====
// back part: rotation and projection on one shared multiplier
`timescale 1ns / 1ps
module gprp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gprp_pkg::csr_type      csr,
   input  gprp_pkg::q_status_type q_status,
   input  gprp_pkg::entry_type    pop_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [22:0]     rsp_proj_x,
   output logic signed [22:0]     rsp_proj_y,
   output logic signed [15:0]     rsp_min_height,
   output logic signed [15:0]     rsp_max_height
);
   import gprp_pkg::*;

   localparam logic [15:0] CX = 16'(CENTER_X);
   localparam logic [15:0] CY = 16'(CENTER_Y);
   localparam logic signed [28:0] OUT_MAX = 29'sd4194303;
   localparam logic signed [28:0] OUT_MIN = -29'sd4194304;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_M0   = 9'b000000010,
      ST_M1   = 9'b000000100,
      ST_M2   = 9'b000001000,
      ST_M3   = 9'b000010000,
      ST_M4   = 9'b000100000,
      ST_M5   = 9'b001000000,
      ST_M6   = 9'b010000000,
      ST_M7   = 9'b100000000
   } back_state_type;

   back_state_type     state_ff, state_in;
   entry_type          ent_ff, ent_in;
   logic signed [41:0] acc_ff, acc_in, prod_ff, prod_in;
   logic signed [24:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [26:0] hterm_ff, hterm_in;
   logic signed [22:0] px_ff, px_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [22:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [15:0] out_lo_ff, out_lo_in, out_hi_ff, out_hi_in;

   logic signed [21:0] dx, dy;
   logic signed [25:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [41:0] mul_res, rot_diff, rot_sum;
   logic signed [28:0] py_pre;
   logic               load;

   // saturate to the 23-bit screen range
   function automatic logic signed [22:0] sat23(input logic signed [28:0] v);
      if (v > OUT_MAX) begin
         return 23'sh3FFFFF;
      end else if (v < OUT_MIN) begin
         return 23'sh400000;
      end
      return v[22:0];
   endfunction

   // offsets from the rotation center
   assign dx = $signed({1'b0, ent_ff.x} - {6'd0, CX});
   assign dy = $signed({1'b0, ent_ff.y} - {6'd0, CY});

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M0: begin
            mul_a = {{4{dx[21]}}, dx};
            mul_b = csr.cos_a;
         end
         ST_M1: begin
            mul_a = {{4{dy[21]}}, dy};
            mul_b = csr.sin_a;
         end
         ST_M2: begin
            mul_a = {{4{dx[21]}}, dx};
            mul_b = csr.sin_a;
         end
         ST_M3: begin
            mul_a = {{4{dy[21]}}, dy};
            mul_b = csr.cos_a;
         end
         ST_M4: begin
            mul_a = {{10{ent_ff.height[15]}}, ent_ff.height};
            mul_b = {{5{csr.height_scale[10]}}, csr.height_scale};
         end
         ST_M5: begin
            mul_a = {rx_ff[24], rx_ff} - {ry_ff[24], ry_ff};
            mul_b = csr.cos_b;
         end
         ST_M6: begin
            mul_a = {rx_ff[24], rx_ff} + {ry_ff[24], ry_ff};
            mul_b = csr.sin_b;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res  = mul_a * mul_b;
   assign rot_diff = acc_ff - prod_ff;
   assign rot_sum  = acc_ff + prod_ff;
   assign py_pre   = $signed({prod_ff[41], prod_ff[41:14]})
                   - $signed({{2{hterm_ff[26]}}, hterm_ff});
   assign load     = (state_ff == ST_M7) && (!rsp_valid_ff || !rsp_stall);
   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      hterm_in     = hterm_ff;
      px_in        = px_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_lo_in    = out_lo_ff;
      out_hi_in    = out_hi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               ent_in   = pop_data;
               state_in = ST_M0;
            end
         end
         ST_M0: begin
            prod_in  = mul_res;
            state_in = ST_M1;
         end
         ST_M1: begin
            acc_in   = prod_ff;
            prod_in  = mul_res;
            state_in = ST_M2;
         end
         ST_M2: begin
            rx_in    = rot_diff[38:14];
            prod_in  = mul_res;
            state_in = ST_M3;
         end
         ST_M3: begin
            acc_in   = prod_ff;
            prod_in  = mul_res;
            state_in = ST_M4;
         end
         ST_M4: begin
            ry_in    = rot_sum[38:14];
            prod_in  = mul_res;
            state_in = ST_M5;
         end
         ST_M5: begin
            hterm_in = prod_ff[26:0];
            prod_in  = mul_res;
            state_in = ST_M6;
         end
         ST_M6: begin
            px_in    = sat23($signed({prod_ff[41], prod_ff[41:14]}));
            prod_in  = mul_res;
            state_in = ST_M7;
         end
         ST_M7: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               out_x_in     = px_ff;
               out_y_in     = sat23(py_pre);
               out_lo_in    = ent_ff.low;
               out_hi_in    = ent_ff.high;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and output word
   always_ff @(posedge clock) begin
      ent_ff    <= ent_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      hterm_ff  <= hterm_in;
      px_ff     <= px_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_lo_ff <= out_lo_in;
      out_hi_ff <= out_hi_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_proj_x     = out_x_ff;
   assign rsp_proj_y     = out_y_ff;
   assign rsp_min_height = out_lo_ff;
   assign rsp_max_height = out_hi_ff;

endmodule

// ===== hw/rtl/grid_point_rotate_project_top.sv =====
// top level of the grid point rotate and project block
`timescale 1ns / 1ps
// Heightmap samples enter in row-major order on the req_ channel and leave as
// projected screen points with the running height range on the rsp_ channel,
// one word out for each word in. The front takes a sample in any cycle that
// the four-entry queue has room. While the result side stalls, up to six
// samples are absorbed before the source sees a stall: four waiting in the
// queue, one held in the back and one finished word in the output register.
// The back works on one sample at a time: it takes the word from the queue and
// then runs eight steps around a single 26 x 16 bit multiplier that forms the
// seven products of rotation, projection and height scaling; that multiplier
// sets the sustained sample rate, and a stall on the result side holds the last step.
// The user must write configuration through csr_ only while the block is
// idle; the block itself does not enforce it.
module grid_point_rotate_project_top #(
   parameter int MAX_COLUMNS = gprp_pkg::MAX_COLUMNS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_height,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [22:0] rsp_proj_x,
   output logic signed [22:0] rsp_proj_y,
   output logic signed [15:0] rsp_min_height,
   output logic signed [15:0] rsp_max_height,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   import gprp_pkg::*;

   csr_type      csr_ff, csr_in;
   q_status_type q_status;
   entry_type    push_data, pop_data;
   logic         push, pop;

   // register writes, unknown indexes ignored
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COS_A:        csr_in.cos_a        = csr_wr_data;
            CSR_SIN_A:        csr_in.sin_a        = csr_wr_data;
            CSR_COS_B:        csr_in.cos_b        = csr_wr_data;
            CSR_SIN_B:        csr_in.sin_b        = csr_wr_data;
            CSR_STEP_COL:     csr_in.step_col     = csr_wr_data[9:0];
            CSR_STEP_ROW:     csr_in.step_row     = csr_wr_data[9:0];
            CSR_HEIGHT_SCALE: csr_in.height_scale = csr_wr_data[10:0];
            CSR_COLUMNS:      csr_in.columns      = csr_wr_data[COLS_W-1:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.cos_a        <= 16'sd16384;
         csr_ff.sin_a        <= 16'sd0;
         csr_ff.cos_b        <= 16'sd16384;
         csr_ff.sin_b        <= 16'sd0;
         csr_ff.step_col     <= 10'd16;
         csr_ff.step_row     <= 10'd16;
         csr_ff.height_scale <= 11'sd1;
         csr_ff.columns      <= COLS_W'(16);
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front: position and height range
   gprp_front #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_height     (req_height),
      .req_frame_start(req_frame_start),
      .csr            (csr_ff),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   // queue between the parts
   gprp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .q_status (q_status)
   );

   // back: rotation and projection
   gprp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .q_status      (q_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_proj_x    (rsp_proj_x),
      .rsp_proj_y    (rsp_proj_y),
      .rsp_min_height(rsp_min_height),
      .rsp_max_height(rsp_max_height)
   );

endmodule
